>>> hdl/rpn_pkg.sv
// Shared types and constants for the postfix expression evaluator.
// Used by rpn_ctrl, rpn_dp and postfix_expression_evaluator; depends on nothing.
package rpn_pkg;

    localparam int DEFAULT_STACK_DEPTH = 128;
    localparam int WORD_W = 32;
    localparam int LIT_W = 31;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 3;
    localparam int DEPTH_W = 8;
    localparam int DIV_STEPS = 32;
    localparam int DCNT_W = 6;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH = 3'd0,
        ACT_ADD  = 3'd1,
        ACT_SUB  = 3'd2,
        ACT_MUL  = 3'd3,
        ACT_DIV  = 3'd4,
        ACT_POW  = 3'd5,
        ACT_NEG  = 3'd6,
        ACT_END  = 3'd7
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_UNDEFINED = 3'd2,
        ST_FINAL     = 3'd3,
        ST_SKIPPED   = 3'd4
    } t_status;

    // Source of the answer field when a result is reported.
    typedef enum logic [1:0] {
        ANS_ZERO    = 2'd0,
        ANS_LITERAL = 2'd1,
        ANS_RESULT  = 2'd2,
        ANS_RD      = 2'd3
    } t_ans_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;        // latch the request fields
        logic     rd_next;     // read address: 0 top entry, 1 entry below top
        logic     cap_b;       // right operand from read data
        logic     cap_a;       // left operand from read data
        logic     cap_result;  // register the operation's result
        logic     unit_start;  // load the divider or the power unit
        logic     unit_run;    // advance the divider or the power unit
        logic     push;        // write the literal on top, count up
        logic     wb;          // write the result back, pop when binary
        logic     set_fail;
        logic     clear_expr;  // empty the stack and clear the error flag
        logic     report;      // present a result next cycle
        t_status  status;
        t_ans_sel ans;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_action action;
        logic    empty;
        logic    one;
        logic    lt2;
        logic    full;
        logic    failed;
        logic    b_zero;
        logic    b_neg;
        logic    iter_done;
    } t_stat;

endpackage

>>> hdl/rpn_ctrl.sv
// Controller state machine of the postfix expression evaluator.
// Depends on rpn_pkg; drives the command struct consumed by rpn_dp.
module rpn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  rpn_pkg::t_stat i_stat,
    output rpn_pkg::t_cmd  o_cmd,
    output logic          o_busy
);
    import rpn_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_DECODE  = 9'b000000010,
        S_RD_TOP  = 9'b000000100,
        S_RD_NEXT = 9'b000001000,
        S_GET_A   = 9'b000010000,
        S_EXEC    = 9'b000100000,
        S_ITER    = 9'b001000000,
        S_WRITE   = 9'b010000000,
        S_SPARE   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd = '0;
        cmd.status = ST_OK;
        cmd.ans = ANS_ZERO;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                if (i_stat.action == ACT_END) begin
                    if (i_stat.failed) begin
                        cmd.report = 1'b1;
                        cmd.status = ST_SKIPPED;
                        cmd.clear_expr = 1'b1;
                    end else if (i_stat.one) begin
                        n_state = S_RD_TOP;
                    end else begin
                        cmd.report = 1'b1;
                        cmd.status = ST_INVALID;
                        cmd.clear_expr = 1'b1;
                    end
                end else if (i_stat.failed) begin
                    cmd.report = 1'b1;
                    cmd.status = ST_SKIPPED;
                end else if (i_stat.action == ACT_PUSH) begin
                    cmd.report = 1'b1;
                    if (i_stat.full) begin
                        cmd.status = ST_INVALID;
                        cmd.set_fail = 1'b1;
                    end else begin
                        cmd.push = 1'b1;
                        cmd.status = ST_OK;
                        cmd.ans = ANS_LITERAL;
                    end
                end else if ((i_stat.action == ACT_NEG && i_stat.empty) ||
                             (i_stat.action != ACT_NEG && i_stat.lt2)) begin
                    cmd.report = 1'b1;
                    cmd.status = ST_INVALID;
                    cmd.set_fail = 1'b1;
                end else begin
                    n_state = S_RD_TOP;
                end
            end
            S_RD_TOP: begin
                n_state = S_RD_NEXT;
            end
            S_RD_NEXT: begin
                // Read data now holds the top entry.
                cmd.cap_b = 1'b1;
                cmd.rd_next = 1'b1;
                if (i_stat.action == ACT_END) begin
                    cmd.report = 1'b1;
                    cmd.status = ST_FINAL;
                    cmd.ans = ANS_RD;
                    cmd.clear_expr = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.action == ACT_NEG) begin
                    n_state = S_EXEC;
                end else begin
                    n_state = S_GET_A;
                end
            end
            S_GET_A: begin
                cmd.cap_a = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if ((i_stat.action == ACT_DIV && i_stat.b_zero) ||
                    (i_stat.action == ACT_POW && i_stat.b_neg)) begin
                    cmd.report = 1'b1;
                    cmd.status = ST_UNDEFINED;
                    cmd.set_fail = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.action == ACT_DIV || i_stat.action == ACT_POW) begin
                    cmd.unit_start = 1'b1;
                    n_state = S_ITER;
                end else begin
                    cmd.cap_result = 1'b1;
                    n_state = S_WRITE;
                end
            end
            S_ITER: begin
                cmd.unit_run = 1'b1;
                if (i_stat.iter_done) begin
                    cmd.cap_result = 1'b1;
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                cmd.wb = 1'b1;
                cmd.report = 1'b1;
                cmd.status = ST_OK;
                cmd.ans = ANS_RESULT;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

>>> hdl/rpn_dp.sv
// Datapath of the postfix expression evaluator: operand stack memory, ALU,
// shared multiplier, iterative divider and power unit, result registers.
// Depends on rpn_pkg; driven by the command struct from rpn_ctrl.
module rpn_dp #(
    parameter int STACK_DEPTH = rpn_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rpn_pkg::t_cmd                   i_cmd,
    output rpn_pkg::t_stat                  o_stat,
    input  logic [rpn_pkg::ACTION_W-1:0]    i_action,
    input  logic [rpn_pkg::LIT_W-1:0]       i_literal,
    output logic                            o_done,
    output logic [rpn_pkg::STATUS_W-1:0]    o_status,
    output logic signed [rpn_pkg::WORD_W-1:0] o_answer,
    output logic [rpn_pkg::DEPTH_W-1:0]     o_depth_now
);
    import rpn_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = (CW > DEPTH_W) ? CW : DEPTH_W;

    t_action           r_action;
    logic [LIT_W-1:0]  r_literal;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_failed;

    logic [WORD_W-1:0] mem [STACK_DEPTH];
    logic [WORD_W-1:0] r_rd_data;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic [WORD_W-1:0] r_result;

    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_quo;
    logic [WORD_W-1:0] r_den;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_neg;

    logic [WORD_W-1:0] r_acc;
    logic [WORD_W-1:0] r_base;
    logic [LIT_W-1:0]  r_exp;
    logic              r_phase;

    logic              r_done;
    t_status           r_status;
    logic [WORD_W-1:0] r_answer;
    logic [DEPTH_W-1:0] r_depth;

    logic [CW-1:0]     count_m1;
    logic [CW-1:0]     count_m2;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              wr_en;
    logic              pop;
    logic [WORD_W-1:0] lit_word;

    logic [WORD_W-1:0] mul_x;
    logic [WORD_W-1:0] mul_y;
    logic [WORD_W-1:0] mul_p;
    logic [WORD_W-1:0] alu;

    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   rem_sub;
    logic              fits;
    logic [WORD_W-1:0] a_abs;
    logic [WORD_W-1:0] b_abs;
    logic [WORD_W-1:0] div_res;
    logic              div_done;
    logic [DW-1:0]     depth_wide;
    logic [WORD_W-1:0] ans_val;

    assign lit_word = {1'b0, r_literal};
    assign count_m1 = r_count - CW'(1);
    assign count_m2 = r_count - CW'(2);
    assign rd_addr = i_cmd.rd_next ? count_m2[AW-1:0] : count_m1[AW-1:0];
    assign pop = (r_action != ACT_NEG);

    assign wr_en = i_cmd.push | i_cmd.wb;
    assign wr_addr = i_cmd.push ? r_count[AW-1:0] :
                     (pop ? count_m2[AW-1:0] : count_m1[AW-1:0]);
    assign wr_data = i_cmd.push ? lit_word : r_result;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.clear_expr) begin
            n_count = '0;
        end else if (i_cmd.push) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.wb && pop) begin
            n_count = count_m1;
        end
    end

    // One multiplier serves the multiply operation and both power steps.
    // Only the low word of the product is kept.
    assign mul_x = i_cmd.unit_run ? (r_phase ? r_base : r_acc) : r_a;
    assign mul_y = i_cmd.unit_run ? r_base : r_b;
    assign mul_p = mul_x * mul_y;

    always_comb begin
        case (r_action)
            ACT_ADD: alu = r_a + r_b;
            ACT_SUB: alu = r_a - r_b;
            ACT_MUL: alu = mul_p;
            ACT_NEG: alu = '0 - r_b;
            default: alu = r_a;
        endcase
    end

    // Restoring division on magnitudes, one quotient bit per cycle.
    assign a_abs = r_a[WORD_W-1] ? ('0 - r_a) : r_a;
    assign b_abs = r_b[WORD_W-1] ? ('0 - r_b) : r_b;
    assign rem_sh = {r_rem, r_quo[WORD_W-1]};
    assign fits = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign div_res = r_neg ? ('0 - r_quo) : r_quo;
    assign div_done = (r_dcnt == DCNT_W'(DIV_STEPS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_literal <= i_literal;
        end
        if (i_cmd.cap_b) begin
            r_b <= r_rd_data;
        end
        if (i_cmd.cap_a) begin
            r_a <= r_rd_data;
        end
        if (i_cmd.cap_result) begin
            if (r_action == ACT_DIV) begin
                r_result <= div_res;
            end else if (r_action == ACT_POW) begin
                r_result <= r_acc;
            end else begin
                r_result <= alu;
            end
        end
        if (i_cmd.unit_start) begin
            r_rem <= '0;
            r_quo <= a_abs;
            r_den <= b_abs;
            r_dcnt <= '0;
            r_neg <= r_a[WORD_W-1] ^ r_b[WORD_W-1];
            r_acc <= WORD_W'(1);
            r_base <= r_a;
            r_exp <= r_b[LIT_W-1:0];
            r_phase <= 1'b0;
        end else if (i_cmd.unit_run) begin
            if (r_action == ACT_DIV) begin
                if (!div_done) begin
                    r_rem <= fits ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
                    r_quo <= {r_quo[WORD_W-2:0], fits};
                    r_dcnt <= r_dcnt + DCNT_W'(1);
                end
            end else if (r_exp != '0) begin
                // Square and multiply: multiply phase, then squaring phase.
                if (!r_phase) begin
                    if (r_exp[0]) begin
                        r_acc <= mul_p;
                    end
                    r_phase <= 1'b1;
                end else begin
                    r_base <= mul_p;
                    r_exp <= r_exp >> 1;
                    r_phase <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_failed <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.clear_expr) begin
                r_failed <= 1'b0;
            end else if (i_cmd.set_fail) begin
                r_failed <= 1'b1;
            end
            r_done <= i_cmd.report;
        end
    end

    always_comb begin
        case (i_cmd.ans)
            ANS_LITERAL: ans_val = lit_word;
            ANS_RESULT:  ans_val = r_result;
            ANS_RD:      ans_val = r_rd_data;
            default:     ans_val = '0;
        endcase
    end

    assign depth_wide = DW'(n_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            r_status <= i_cmd.status;
            r_answer <= ans_val;
            r_depth <= depth_wide[DEPTH_W-1:0];
        end
    end

    always_comb begin
        o_stat.action = r_action;
        o_stat.empty = (r_count == '0);
        o_stat.one = (r_count == CW'(1));
        o_stat.lt2 = (r_count < CW'(2));
        o_stat.full = (r_count == CW'(STACK_DEPTH));
        o_stat.failed = r_failed;
        o_stat.b_zero = (r_b == '0);
        o_stat.b_neg = r_b[WORD_W-1];
        o_stat.iter_done = (r_action == ACT_DIV) ? div_done : (r_exp == '0);
    end

    assign o_done = r_done;
    assign o_status = r_status;
    assign o_answer = $signed(r_answer);
    assign o_depth_now = r_depth;

endmodule

>>> hdl/postfix_expression_evaluator.sv
// Top level of the postfix expression evaluator.
// Depends on rpn_pkg and instantiates rpn_ctrl and rpn_dp.
//
// Usage: a request is taken at a rising edge where start is high and busy is
// low; i_action selects push, add, subtract, multiply, divide, power, negate
// or end, and i_literal is the value pushed. Every request produces exactly
// one result, shown on o_status, o_answer and o_depth_now for one cycle while
// o_done is high. The receiver has no way to stall; it must take the result
// in that cycle. The result register is separate from the control, so busy
// drops in the same cycle the result strobe rises.
// Pushes, stack errors, skipped requests and ends with no value report from
// decode; an end with a value reads it from the top entry. Other operations
// read the top entry, then, but for negate, the entry below; a divide by zero
// or negative exponent reports from execute. Divide runs the divider a quotient
// bit at a time, and power a square-and-multiply loop over the exponent bits
// on the single shared 32-bit multiplier, then write back. Busy is low again in
// the strobe's cycle, so the next request can be taken at the edge that ends it.
// Reset (i_rst_n low at a clock edge) empties the stack, clears the error
// flag and drops o_done; the stack memory itself is not cleared, since only
// entries written in the current expression are ever read.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = rpn_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rpn_pkg::ACTION_W-1:0]      i_action,
    input  logic [rpn_pkg::LIT_W-1:0]         i_literal,
    output logic                              o_done,
    output logic [rpn_pkg::STATUS_W-1:0]      o_status,
    output logic signed [rpn_pkg::WORD_W-1:0] o_answer,
    output logic [rpn_pkg::DEPTH_W-1:0]       o_depth_now
);
    import rpn_pkg::*;

    // Commands and status between the state machine and the datapath.
    t_cmd  cmd;
    t_stat stat;
    logic  ctrl_busy;

    // The controller sequences each request: decode and error checks, stack
    // reads, arithmetic or the iterative units, write-back and reporting.
    rpn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (ctrl_busy)
    );

    // The datapath holds the operand stack, the depth counter, the error flag,
    // the arithmetic units and the registered result ports.
    rpn_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_action    (i_action),
        .i_literal   (i_literal),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_answer    (o_answer),
        .o_depth_now (o_depth_now)
    );

    assign busy = ctrl_busy;

endmodule
